@@ hdl/wsb_pkg.sv @@
// shared types, constants and helper functions of the wheel speed balancer
package wsb_pkg;

  // fixed formats
  localparam int SPEED_FRAC_BITS = 14;
  localparam int COUNT_BITS      = 32;
  localparam int SPEED_W         = 16;
  localparam int RATE_W          = 32;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int DIV_NUM_W       = 48;
  localparam int DIV_DEN_W       = 32;
  localparam int MUL_A_W         = 33;
  localparam int PROD_W          = MUL_A_W + CFG_W;
  localparam int EXT_W           = 25;
  localparam int AMT_W           = 17;
  localparam int PROP_SHIFT      = 24 - SPEED_FRAC_BITS;
  localparam int SIDE_SHIFT      = 8;

  // stream packing
  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // full scale speed, twice that, and the side product limit
  localparam logic signed [17:0] ONE_W  = 18'(longint'(1) << SPEED_FRAC_BITS);
  localparam logic signed [15:0] ONE_S  = 16'(longint'(1) << SPEED_FRAC_BITS);
  localparam logic [PROD_W-1:0]  TWO_ONE_P = PROD_W'(longint'(2) << SPEED_FRAC_BITS);
  localparam logic [AMT_W-1:0]   TWO_ONE_A = AMT_W'(longint'(2) << SPEED_FRAC_BITS);
  localparam logic [PROD_W-1:0]  SIDE_LIMIT = PROD_W'(longint'(1) << (SPEED_FRAC_BITS + 8));

  // register reset values
  localparam logic [CFG_W-1:0] GAIN_RST        = 16'd256;
  localparam logic [CFG_W-1:0] SIDE_FACTOR_RST = 16'd282;
  localparam logic [CFG_W-1:0] SIDE_MULT_RST   = 16'd256;
  localparam logic [CFG_W-1:0] PERIOD_RST      = 16'd10;

  // register indexes
  localparam logic [1:0] REG_GAIN        = 2'd0;
  localparam logic [1:0] REG_SIDE_FACTOR = 2'd1;
  localparam logic [1:0] REG_SIDE_MULT   = 2'd2;
  localparam logic [1:0] REG_PERIOD      = 2'd3;

  // operation codes
  localparam logic [1:0] OP_FORWARD    = 2'd0;
  localparam logic [1:0] OP_TURN_RIGHT = 2'd1;
  localparam logic [1:0] OP_TURN_LEFT  = 2'd2;
  localparam logic [1:0] OP_STOP       = 2'd3;

  // side request codes
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_ERR   = 2'd0,
    MUL_SIDE  = 2'd1,
    MUL_SCALE = 2'd2
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     apply_direct;
    logic     keep_side;
    logic     start_meas;
    logic     store_rates;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     disarm;
    logic     ext_pick;
    logic     ext_div_start;
    logic     ext_from_div;
    logic     steer_prop;
    logic     steer_ext;
    logic     out_load;
    logic     changed;
  } wsb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_direct;
    logic       tick_due;
    logic [1:0] side;
    logic       armed;
    logic       err_zero;
    logic       side_short;
    logic       div_done;
  } wsb_status_t;

  // saturate to plus or minus full scale
  function automatic logic signed [15:0] clip_speed(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > ONE_W) r = ONE_S;
    else if (v < -ONE_W) r = -ONE_S;
    else r = v[15:0];
    return r;
  endfunction

  // move a level away from or toward zero by c
  function automatic logic signed [15:0] push_level(input logic signed [15:0] level,
                                                    input logic signed [AMT_W-1:0] c,
                                                    input logic away);
    logic signed [17:0] l;
    logic signed [17:0] cc;
    logic signed [17:0] sum;
    l  = {{2{level[15]}}, level};
    cc = {c[AMT_W-1], c};
    if ((level > 16'sd0) == away) sum = l + cc;
    else sum = l - cc;
    return clip_speed(sum);
  endfunction

  // magnitude of a level
  function automatic logic [15:0] abs_level(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // magnitude of a step count
  function automatic logic [COUNT_BITS-1:0] abs_count(input logic signed [COUNT_BITS-1:0] v);
    return v[COUNT_BITS-1] ? COUNT_BITS'(-v) : COUNT_BITS'(v);
  endfunction

  // signed rate from magnitude quotient, saturated to 32 bit
  function automatic logic signed [RATE_W-1:0] sat_rate(input logic neg,
                                                        input logic [DIV_NUM_W-1:0] q);
    logic signed [RATE_W-1:0] r;
    if (neg) begin
      if (q > DIV_NUM_W'(64'h8000_0000)) r = 32'sh8000_0000;
      else r = -$signed(q[RATE_W-1:0]);
    end else begin
      if (q > DIV_NUM_W'(64'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else r = $signed(q[RATE_W-1:0]);
    end
    return r;
  endfunction

endpackage

@@ hdl/wsb_div.sv @@
// restoring divider, one quotient bit per cycle
module wsb_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wsb_pkg::DIV_NUM_W-1:0]  num,
  input  logic [wsb_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [wsb_pkg::DIV_NUM_W-1:0]  quo
);

  localparam int CNT_W = $clog2(wsb_pkg::DIV_NUM_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              count;
  logic [wsb_pkg::DIV_DEN_W-1:0] rem;
  logic [wsb_pkg::DIV_DEN_W-1:0] den_q;
  logic [wsb_pkg::DIV_DEN_W:0]   trial;
  logic                          fits;

  // one trial subtraction
  always_comb begin
    trial = {rem, quo[wsb_pkg::DIV_NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(wsb_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? wsb_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                  : trial[wsb_pkg::DIV_DEN_W-1:0];
      quo <= {quo[wsb_pkg::DIV_NUM_W-2:0], fits};
    end
  end

endmodule

@@ hdl/wsb_datapath.sv @@
// registers, shared multiplier, dividers and steering of the balancer
module wsb_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  wsb_pkg::wsb_cmd_t               cmd,
  output wsb_pkg::wsb_status_t            status,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [wsb_pkg::CFG_W-1:0]       cfg_data,
  input  logic [wsb_pkg::IN_DATA_W-1:0]   in_data,
  input  logic [wsb_pkg::IN_USER_W-1:0]   in_user,
  output logic [wsb_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [wsb_pkg::OUT_USER_W-1:0]  out_user
);

  // configuration
  logic [wsb_pkg::CFG_W-1:0] gain, side_factor, side_mult, update_period;

  // captured word
  logic [1:0]                              op;
  logic signed [15:0]                      speed;
  logic [1:0]                              side;
  logic [wsb_pkg::TIME_W-1:0]              now_ms;
  logic signed [wsb_pkg::COUNT_BITS-1:0]   left_steps, right_steps;

  // balancer state
  logic signed [15:0]                      left_goal, right_goal, left_level, right_level;
  logic signed [wsb_pkg::RATE_W-1:0]       left_rate, right_rate;
  logic                                    correction_armed;
  logic [wsb_pkg::TIME_W-1:0]              last_tick;
  logic signed [wsb_pkg::COUNT_BITS-1:0]   left_snapshot, right_snapshot;
  logic [1:0]                              last_side;

  // working registers
  logic                                    left_neg, right_neg;
  logic [wsb_pkg::PROD_W-1:0]              prod;
  logic signed [wsb_pkg::EXT_W-1:0]        ext_c;
  logic                                    ratio_div;

  // divider connections
  logic [wsb_pkg::DIV_NUM_W-1:0]           l_num, r_num, l_quo, r_quo;
  logic [wsb_pkg::DIV_DEN_W-1:0]           l_den;
  logic                                    l_done, r_done;

  // combinational helpers
  logic signed [15:0]                      speed_in;
  logic [wsb_pkg::TIME_W-1:0]              dt;
  logic [wsb_pkg::CFG_W-1:0]               period_eff;
  logic signed [wsb_pkg::COUNT_BITS:0]     l_diff, r_diff;
  logic [wsb_pkg::COUNT_BITS-1:0]          l_mag, r_mag;
  logic signed [wsb_pkg::RATE_W:0]         err;
  logic [wsb_pkg::MUL_A_W-1:0]             abs_err;
  logic [15:0]                             lead, other, turn_mag;
  logic [wsb_pkg::MUL_A_W-1:0]             mul_a;
  logic [wsb_pkg::CFG_W-1:0]               mul_b;
  logic signed [wsb_pkg::AMT_W-1:0]        ext_clamped;
  logic [wsb_pkg::AMT_W-1:0]               ext_abs;
  logic [wsb_pkg::PROD_W-1:0]              p_prop, p_ext;
  logic signed [wsb_pkg::AMT_W-1:0]        prop_amt, ext_amt, amt;
  logic                                    go_left;
  logic signed [15:0]                      ll_n, rl_n, turn_left_goal;

  // saturate incoming speed
  assign speed_in = wsb_pkg::clip_speed({{2{in_data[15]}}, in_data[15:0]});

  // period check
  always_comb begin
    dt         = now_ms - last_tick;
    period_eff = (update_period == '0) ? wsb_pkg::CFG_W'(1) : update_period;
  end

  // rate numerators from count magnitudes
  always_comb begin
    l_diff = $signed({1'b0, wsb_pkg::abs_count(left_steps)})
           - $signed({1'b0, wsb_pkg::abs_count(left_snapshot)});
    r_diff = $signed({1'b0, wsb_pkg::abs_count(right_steps)})
           - $signed({1'b0, wsb_pkg::abs_count(right_snapshot)});
    l_mag  = l_diff[wsb_pkg::COUNT_BITS] ? wsb_pkg::COUNT_BITS'(-l_diff)
                                         : l_diff[wsb_pkg::COUNT_BITS-1:0];
    r_mag  = r_diff[wsb_pkg::COUNT_BITS] ? wsb_pkg::COUNT_BITS'(-r_diff)
                                         : r_diff[wsb_pkg::COUNT_BITS-1:0];
  end

  // rate error and side operands
  always_comb begin
    err     = $signed({left_rate[wsb_pkg::RATE_W-1], left_rate})
            - $signed({right_rate[wsb_pkg::RATE_W-1], right_rate});
    abs_err = err[wsb_pkg::RATE_W] ? wsb_pkg::MUL_A_W'(-err) : wsb_pkg::MUL_A_W'(err);
    lead    = (side == wsb_pkg::SIDE_RIGHT) ? wsb_pkg::abs_level(left_level)
                                            : wsb_pkg::abs_level(right_level);
    other   = (side == wsb_pkg::SIDE_RIGHT) ? wsb_pkg::abs_level(right_level)
                                            : wsb_pkg::abs_level(left_level);
    turn_mag = wsb_pkg::abs_level(speed);
    turn_left_goal = (op == wsb_pkg::OP_TURN_RIGHT) ? $signed(turn_mag) : -$signed(turn_mag);
  end

  // external correction clamped to twice full scale
  always_comb begin
    if (ext_c > $signed(wsb_pkg::EXT_W'(wsb_pkg::TWO_ONE_A)))
      ext_clamped = $signed(wsb_pkg::TWO_ONE_A);
    else if (ext_c < -$signed(wsb_pkg::EXT_W'(wsb_pkg::TWO_ONE_A)))
      ext_clamped = -$signed(wsb_pkg::TWO_ONE_A);
    else
      ext_clamped = ext_c[wsb_pkg::AMT_W-1:0];
    ext_abs = ext_clamped[wsb_pkg::AMT_W-1] ? wsb_pkg::AMT_W'(-ext_clamped)
                                            : wsb_pkg::AMT_W'(ext_clamped);
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      wsb_pkg::MUL_ERR: begin
        mul_a = abs_err;
        mul_b = gain;
      end
      wsb_pkg::MUL_SIDE: begin
        mul_a = wsb_pkg::MUL_A_W'(lead);
        mul_b = side_factor;
      end
      wsb_pkg::MUL_SCALE: begin
        mul_a = wsb_pkg::MUL_A_W'(ext_abs);
        mul_b = side_mult;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // correction amounts, limited to twice full scale
  always_comb begin
    p_prop   = prod >> wsb_pkg::PROP_SHIFT;
    p_ext    = prod >> wsb_pkg::SIDE_SHIFT;
    prop_amt = (p_prop > wsb_pkg::TWO_ONE_P) ? $signed(wsb_pkg::TWO_ONE_A)
                                             : $signed(p_prop[wsb_pkg::AMT_W-1:0]);
    ext_amt  = (p_ext > wsb_pkg::TWO_ONE_P) ? $signed(wsb_pkg::TWO_ONE_A)
                                            : $signed(p_ext[wsb_pkg::AMT_W-1:0]);
    if (ext_c < 0) ext_amt = -ext_amt;
    amt     = cmd.steer_prop ? prop_amt : ext_amt;
    go_left = cmd.steer_prop ? (err > 0) : (side == wsb_pkg::SIDE_LEFT);
  end

  // steering: raise the slower drive unless it is at full scale
  always_comb begin
    ll_n = left_level;
    rl_n = right_level;
    if (go_left) begin
      if (right_level != wsb_pkg::ONE_S && right_level != -wsb_pkg::ONE_S)
        rl_n = wsb_pkg::push_level(right_level, amt, 1'b1);
      else
        ll_n = wsb_pkg::push_level(left_level, amt, 1'b0);
    end else begin
      if (left_level != wsb_pkg::ONE_S && left_level != -wsb_pkg::ONE_S)
        ll_n = wsb_pkg::push_level(left_level, amt, 1'b1);
      else
        rl_n = wsb_pkg::push_level(right_level, amt, 1'b0);
    end
  end

  // divider inputs: both rates, or the external ratio on the left unit
  always_comb begin
    l_num = cmd.ext_div_start ? wsb_pkg::DIV_NUM_W'({lead, 8'b0})
                              : {l_mag, 16'b0};
    l_den = cmd.ext_div_start ? wsb_pkg::DIV_DEN_W'(side_factor) : dt;
    r_num = {r_mag, 16'b0};
  end

  wsb_div u_div_left (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start_meas | cmd.ext_div_start),
    .num  (l_num),
    .den  (l_den),
    .done (l_done),
    .quo  (l_quo)
  );

  wsb_div u_div_right (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start_meas),
    .num  (r_num),
    .den  (dt),
    .done (r_done),
    .quo  (r_quo)
  );

  // status toward the controller
  always_comb begin
    status.is_direct  = (op != wsb_pkg::OP_FORWARD) || (left_goal != speed)
                     || (right_goal != speed) || (last_side != side);
    status.tick_due   = dt >= wsb_pkg::TIME_W'(period_eff);
    status.side       = side;
    status.armed      = correction_armed;
    status.err_zero   = left_rate == right_rate;
    status.side_short = (prod < wsb_pkg::SIDE_LIMIT) || (side_factor == '0);
    status.div_done   = l_done & (r_done | ratio_div);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= wsb_pkg::GAIN_RST;
      side_factor   <= wsb_pkg::SIDE_FACTOR_RST;
      side_mult     <= wsb_pkg::SIDE_MULT_RST;
      update_period <= wsb_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsb_pkg::REG_GAIN:        gain          <= cfg_data;
        wsb_pkg::REG_SIDE_FACTOR: side_factor   <= cfg_data;
        wsb_pkg::REG_SIDE_MULT:   side_mult     <= cfg_data;
        wsb_pkg::REG_PERIOD:      update_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op          <= in_user;
      speed       <= speed_in;
      side        <= in_data[17:16];
      now_ms      <= in_data[49:18];
      left_steps  <= in_data[81:50];
      right_steps <= in_data[113:82];
    end
  end

  // balancer state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_goal        <= '0;
      right_goal       <= '0;
      left_level       <= '0;
      right_level      <= '0;
      left_rate        <= '0;
      right_rate       <= '0;
      correction_armed <= 1'b0;
      last_tick        <= '0;
      left_snapshot    <= '0;
      right_snapshot   <= '0;
      last_side        <= wsb_pkg::SIDE_NONE;
    end else begin
      if (cmd.apply_direct) begin
        left_snapshot  <= left_steps;
        right_snapshot <= right_steps;
        if (op == wsb_pkg::OP_STOP) begin
          left_goal   <= '0;
          right_goal  <= '0;
          left_level  <= '0;
          right_level <= '0;
          last_side   <= wsb_pkg::SIDE_NONE;
        end else if (op == wsb_pkg::OP_FORWARD) begin
          correction_armed <= last_side != side;
          left_goal   <= speed;
          right_goal  <= speed;
          left_level  <= speed;
          right_level <= speed;
          last_tick   <= now_ms;
          last_side   <= side;
        end else begin
          left_goal   <= turn_left_goal;
          right_goal  <= -turn_left_goal;
          left_level  <= turn_left_goal;
          right_level <= -turn_left_goal;
          last_tick   <= now_ms;
        end
      end
      if (cmd.keep_side) last_side <= side;
      if (cmd.start_meas) begin
        last_tick      <= now_ms;
        left_snapshot  <= left_steps;
        right_snapshot <= right_steps;
        last_side      <= side;
      end
      if (cmd.store_rates) begin
        left_rate  <= wsb_pkg::sat_rate(left_neg, l_quo);
        right_rate <= wsb_pkg::sat_rate(right_neg, r_quo);
      end
      if (cmd.disarm) correction_armed <= 1'b0;
      if (cmd.steer_prop || cmd.steer_ext) begin
        left_level  <= ll_n;
        right_level <= rl_n;
      end
    end
  end

  // left divider busy with the external ratio rather than a rate
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_div <= 1'b0;
    end else if (cmd.ext_div_start) begin
      ratio_div <= 1'b1;
    end else if (cmd.start_meas) begin
      ratio_div <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start_meas) begin
      left_neg  <= l_diff[wsb_pkg::COUNT_BITS];
      right_neg <= r_diff[wsb_pkg::COUNT_BITS];
    end
    if (cmd.mul_en) prod <= wsb_pkg::PROD_W'(mul_a * mul_b);
    if (cmd.ext_pick)
      ext_c <= $signed({2'b0, prod[30:8]}) - $signed({9'b0, other});
    else if (cmd.ext_from_div)
      ext_c <= $signed({9'b0, lead}) - $signed({1'b0, l_quo[23:0]});
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {right_level, left_level};
      out_user <= cmd.changed;
    end
  end

endmodule

@@ hdl/wsb_ctrl.sv @@
// sequencing state machine and handshakes of the balancer
module wsb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  wsb_pkg::wsb_status_t  status,
  output wsb_pkg::wsb_cmd_t     cmd
);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_DECIDE    = 13'b0000000000010,
    ST_MEAS      = 13'b0000000000100,
    ST_BRANCH    = 13'b0000000001000,
    ST_MUL_PROP  = 13'b0000000010000,
    ST_STEER     = 13'b0000000100000,
    ST_EXT_MUL   = 13'b0000001000000,
    ST_EXT_CHK   = 13'b0000010000000,
    ST_EXT_DIV   = 13'b0000100000000,
    ST_EXT_SCALE = 13'b0001000000000,
    ST_EXT_STEER = 13'b0010000000000,
    ST_FINISH    = 13'b0100000000000,
    ST_WAIT      = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   changed, changed_next;
  logic   out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = ~out_valid | out_ready;

  // next state and commands
  always_comb begin
    state_next   = state;
    changed_next = changed;
    cmd          = '0;
    cmd.mul_sel  = wsb_pkg::MUL_ERR;
    cmd.changed  = changed;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_direct) begin
          cmd.apply_direct = 1'b1;
          changed_next     = 1'b1;
          state_next       = ST_FINISH;
        end else if (status.tick_due) begin
          cmd.start_meas = 1'b1;
          changed_next   = 1'b0;
          state_next     = ST_MEAS;
        end else begin
          cmd.keep_side = 1'b1;
          changed_next  = 1'b0;
          state_next    = ST_FINISH;
        end
      end
      ST_MEAS: begin
        cmd.store_rates = status.div_done;
        if (status.div_done) state_next = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (status.side != wsb_pkg::SIDE_NONE) begin
          if (status.armed) begin
            cmd.disarm = 1'b1;
            if (status.side == wsb_pkg::SIDE_RIGHT || status.side == wsb_pkg::SIDE_LEFT)
              state_next = ST_EXT_MUL;
            else
              state_next = ST_FINISH;
          end else begin
            state_next = ST_FINISH;
          end
        end else if (status.err_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = wsb_pkg::MUL_ERR;
          state_next  = ST_MUL_PROP;
        end
      end
      ST_MUL_PROP: begin
        state_next = ST_STEER;
      end
      ST_STEER: begin
        cmd.steer_prop = 1'b1;
        changed_next   = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_EXT_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wsb_pkg::MUL_SIDE;
        state_next  = ST_EXT_CHK;
      end
      ST_EXT_CHK: begin
        if (status.side_short) begin
          cmd.ext_pick = 1'b1;
          state_next   = ST_EXT_SCALE;
        end else begin
          cmd.ext_div_start = 1'b1;
          state_next        = ST_EXT_DIV;
        end
      end
      ST_EXT_DIV: begin
        cmd.ext_from_div = status.div_done;
        if (status.div_done) state_next = ST_EXT_SCALE;
      end
      ST_EXT_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wsb_pkg::MUL_SCALE;
        state_next  = ST_EXT_STEER;
      end
      ST_EXT_STEER: begin
        cmd.steer_ext = 1'b1;
        changed_next  = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      changed   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      changed <= changed_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/wheel_speed_balancer_top.sv @@
// A stop, turn, goal change or unchanged command before its period is due passes from
// ST_DECIDE via ST_FINISH to ST_WAIT, which loads its result word; a due measurement
// first runs both 48-bit rate dividers side by side, and an external correction that
// needs the ratio divide runs the left divider once more, which is the longest path.
// One word at a time; the next is taken while the result waits. Reset (rst,
// synchronous, active high) clears state and loads defaults.
module wheel_speed_balancer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [wsb_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // speed_request, side_request, now_ms, left_steps, right_steps, zero pad
  input  logic [wsb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [wsb_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_drive, right_drive
  output logic [wsb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // drive_changed
  output logic [wsb_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  wsb_pkg::wsb_cmd_t    cmd;
  wsb_pkg::wsb_status_t status;

  // sequencer
  wsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  wsb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

endmodule

@@ hdl/wsb_checker.sv @@
// port level checks of the balancer, bound to the top level
module wsb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [1:0]                        cfg_index,
  input logic [wsb_pkg::CFG_W-1:0]         cfg_data,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [wsb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input logic [wsb_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [wsb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic [wsb_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one word at a time: no intake right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // drives stay within full scale
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $signed(m_axis_tdata[15:0]) <= $signed(wsb_pkg::ONE_S) &&
      $signed(m_axis_tdata[15:0]) >= -$signed(wsb_pkg::ONE_S) &&
      $signed(m_axis_tdata[31:16]) <= $signed(wsb_pkg::ONE_S) &&
      $signed(m_axis_tdata[31:16]) >= -$signed(wsb_pkg::ONE_S))
    else $error("drive out of range");

  // nothing shown right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind wheel_speed_balancer_top wsb_checker u_wsb_checker (.*);
